[sv/ikw_pkg.sv]
// ----------------------------------------------------------------------------
// ikw_pkg
// Shared types, kernel tables and fixed-point constants for the
// interpolation kernel weight pipeline.
// ----------------------------------------------------------------------------
package ikw_pkg;

   localparam int DIMENSIONS = 2;
   localparam int NUM_OFFSETS = 2;
   localparam int HORNER_STEPS = 9;

   localparam logic [4:0] FRAC_X = 5'd30;
   localparam logic [4:0] SHIFT_F = 5'd28;
   localparam logic [4:0] FRAC_W = 5'd24;

   localparam logic [2:0] K_HAT = 3'd0;
   localparam logic [2:0] K_CUBIC = 3'd1;
   localparam logic [2:0] K_FOUR = 3'd2;
   localparam logic [2:0] K_SIX = 3'd3;
   localparam logic [2:0] K_L21 = 3'd4;
   localparam logic [2:0] K_L22 = 3'd5;
   localparam logic [2:0] K_L42 = 3'd6;
   localparam logic [2:0] K_L44 = 3'd7;

   localparam logic signed [63:0] U = 64'sd1 <<< 36;
   localparam logic [62:0] MAG_CAP = 63'd1 << 62;

   typedef logic signed [63:0] coef_row_type [10];

   typedef struct packed {
      logic        zero;
      logic [1:0]  piece;
      logic [31:0] x;
   } lane_type;

   function automatic logic [1:0] support_len(input logic [2:0] k);
      logic [1:0] s;
      case (k)
         K_HAT: s = 2'd1;
         K_SIX, K_L42, K_L44: s = 2'd3;
         default: s = 2'd2;
      endcase
      return s;
   endfunction

   // Coefficients in ascending powers, signed Q.36, rounded to nearest.
   function automatic coef_row_type coef_row(input logic [2:0] k, input logic [1:0] piece);
      coef_row_type row;
      row = '{default: 64'sd0};
      case ({k, piece})
         {K_HAT, 2'd0}: row = '{U, -U, 0, 0, 0, 0, 0, 0, 0, 0};
         {K_CUBIC, 2'd0}, {K_L21, 2'd0}:
            row = '{U, 0, -((5*U+1)/2), (3*U+1)/2, 0, 0, 0, 0, 0, 0};
         {K_CUBIC, 2'd1}, {K_L21, 2'd1}:
            row = '{2*U, -(4*U), (5*U+1)/2, -((U+1)/2), 0, 0, 0, 0, 0, 0};
         {K_FOUR, 2'd0}:
            row = '{U, -((U+1)/2), -U, (U+1)/2, 0, 0, 0, 0, 0, 0};
         {K_FOUR, 2'd1}:
            row = '{U, -((11*U+3)/6), U, -((U+3)/6), 0, 0, 0, 0, 0, 0};
         {K_SIX, 2'd0}:
            row = '{U, -((U+1)/3), -((5*U+2)/4), (5*U+6)/12, (U+2)/4, -((U+6)/12),
                    0, 0, 0, 0};
         {K_SIX, 2'd1}:
            row = '{U, -((13*U+6)/12), -((5*U+4)/8), (25*U+12)/24, -((3*U+4)/8),
                    (U+12)/24, 0, 0, 0, 0};
         {K_SIX, 2'd2}:
            row = '{U, -((137*U+30)/60), (15*U+4)/8, -((17*U+12)/24), (U+4)/8,
                    -((U+60)/120), 0, 0, 0, 0};
         {K_L22, 2'd0}:
            row = '{U, 0, -U, -((9*U+1)/2), (15*U+1)/2, -(3*U), 0, 0, 0, 0};
         {K_L22, 2'd1}:
            row = '{-(4*U), 18*U, -(29*U), (43*U+1)/2, -((15*U+1)/2), U, 0, 0, 0, 0};
         {K_L42, 2'd0}:
            row = '{U, 0, -((5*U+2)/4), -((35*U+6)/12), (21*U+2)/4, -((25*U+6)/12),
                    0, 0, 0, 0};
         {K_L42, 2'd1}:
            row = '{-(4*U), (75*U+2)/4, -((245*U+4)/8), (545*U+12)/24, -((63*U+4)/8),
                    (25*U+12)/24, 0, 0, 0, 0};
         {K_L42, 2'd2}:
            row = '{18*U, -((153*U+2)/4), (255*U+4)/8, -((313*U+12)/24), (21*U+4)/8,
                    -((5*U+12)/24), 0, 0, 0, 0};
         {K_L44, 2'd0}:
            row = '{U, 0, -((5*U+2)/4), 0, (U+2)/4, -((100*U+1)/3), (455*U+2)/4,
                    -((295*U+1)/2), (345*U+2)/4, -((115*U+3)/6)};
         {K_L44, 2'd1}:
            row = '{-(199*U), (5485*U+2)/4, -((32975*U+4)/8), (28425*U+2)/4,
                    -((61953*U+4)/8), (33175*U+3)/6, -((20685*U+4)/8), (3055*U+2)/4,
                    -((1035*U+4)/8), (115*U+6)/12};
         {K_L44, 2'd2}:
            row = '{5913*U, -((89235*U+2)/4), (297585*U+4)/8, -((143895*U+2)/4),
                    (177871*U+4)/8, -((54641*U+3)/6), (19775*U+4)/8, -((1715*U+2)/4),
                    (345*U+4)/8, -((23*U+6)/12)};
         default: row = '{default: 64'sd0};
      endcase
      return row;
   endfunction

endpackage

[sv/ikw_mulsh.sv]
// ----------------------------------------------------------------------------
// ikw_mulsh
// Four-stage signed multiply, truncating right shift and magnitude cap.
// ----------------------------------------------------------------------------
module ikw_mulsh (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [63:0] in_a,
   input  logic signed [63:0] in_b,
   input  logic [4:0]         shift,
   input  ikw_pkg::lane_type  in_side,
   output logic               out_valid,
   output logic signed [63:0] out_p,
   output ikw_pkg::lane_type  out_side
);
   import ikw_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   lane_type s1_ff, s2_ff, s3_ff, s4_ff;
   logic n1_ff, n2_ff, n3_ff;
   logic [62:0] ma_ff, mb_ff, ma_in, mb_in;
   logic [63:0] ll_ff, ll_in;
   logic [62:0] lh_ff, hl_ff, lh_in, hl_in;
   logic [61:0] hh_ff, hh_in;
   logic [125:0] prod_ff, prod_in, sh;
   logic [62:0] r;
   logic signed [63:0] out_p_ff, out_p_in;
   logic signed [63:0] abs_a, abs_b;

   always_comb begin
      abs_a = in_a[63] ? -in_a : in_a;
      abs_b = in_b[63] ? -in_b : in_b;
      ma_in = abs_a[62:0];
      mb_in = abs_b[62:0];
      ll_in = ma_ff[31:0] * mb_ff[31:0];
      lh_in = ma_ff[31:0] * mb_ff[62:32];
      hl_in = ma_ff[62:32] * mb_ff[31:0];
      hh_in = ma_ff[62:32] * mb_ff[62:32];
      prod_in = 126'(ll_ff) + (126'(lh_ff) << 32) + (126'(hl_ff) << 32)
              + (126'(hh_ff) << 64);
      sh = prod_ff >> shift;
      r = (sh > 126'(MAG_CAP)) ? MAG_CAP : sh[62:0];
      out_p_in = n3_ff ? -$signed({1'b0, r}) : $signed({1'b0, r});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      n1_ff <= in_a[63] ^ in_b[63];
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      s1_ff <= in_side;
      n2_ff <= n1_ff;
      ll_ff <= ll_in;
      lh_ff <= lh_in;
      hl_ff <= hl_in;
      hh_ff <= hh_in;
      s2_ff <= s1_ff;
      n3_ff <= n2_ff;
      prod_ff <= prod_in;
      s3_ff <= s2_ff;
      out_p_ff <= out_p_in;
      s4_ff <= s3_ff;
   end

   assign out_valid = v4_ff;
   assign out_p = out_p_ff;
   assign out_side = s4_ff;

endmodule

[sv/ikw_horner.sv]
// ----------------------------------------------------------------------------
// ikw_horner
// One Horner step: p times x in Q.36, then add the next coefficient.
// ----------------------------------------------------------------------------
module ikw_horner (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [63:0] in_p,
   input  ikw_pkg::lane_type  in_side,
   input  logic [2:0]         k,
   input  logic [3:0]         j,
   output logic               out_valid,
   output logic signed [63:0] out_p,
   output ikw_pkg::lane_type  out_side
);
   import ikw_pkg::*;

   logic m_valid;
   logic signed [63:0] m_p;
   lane_type m_side;
   logic valid_ff;
   logic signed [63:0] p_ff, p_in;
   lane_type side_ff;
   coef_row_type row;

   ikw_mulsh u_mul (
      .clock(clock), .reset(reset), .in_valid(in_valid),
      .in_a(in_p), .in_b($signed({32'b0, in_side.x})), .shift(FRAC_X),
      .in_side(in_side), .out_valid(m_valid), .out_p(m_p), .out_side(m_side)
   );

   always_comb begin
      row = coef_row(k, m_side.piece);
      p_in = m_p + row[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= m_valid;
      end
      p_ff <= p_in;
      side_ff <= m_side;
   end

   assign out_valid = valid_ff;
   assign out_p = p_ff;
   assign out_side = side_ff;

endmodule

[sv/ikw_lane.sv]
// ----------------------------------------------------------------------------
// ikw_lane
// One dimension: scale the offset, pick the piece, evaluate the kernel
// polynomial and scale the kernel value by the inverse spacing.
// ----------------------------------------------------------------------------
module ikw_lane (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic signed [31:0] offset,
   input  logic [2:0]         k,
   input  logic [31:0]        inv,
   output logic               out_valid,
   output logic signed [63:0] f
);
   import ikw_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic [31:0] mag_ff, mag_in;
   logic [63:0] prod_ff, prod_in;
   logic [61:0] x, lim;
   logic [31:0] pw;
   logic closed, zero;
   logic [1:0] piece;
   lane_type side_ff, side_in;
   logic signed [63:0] p_ff, p_in;
   coef_row_type row;

   logic hv [HORNER_STEPS+1];
   logic signed [63:0] hp [HORNER_STEPS+1];
   lane_type hs [HORNER_STEPS+1];

   always_comb begin
      mag_in = offset[31] ? (~offset + 32'd1) : offset;
      prod_in = mag_ff * inv;
      x = prod_ff[63:2];
      lim = 62'(support_len(k)) << 30;
      closed = ~k[2];
      zero = closed ? (x > lim) : (x >= lim);
      pw = x[61:30];
      // Closed pieces take the lower piece at an exact integer point.
      if (closed && pw != 32'd0 && x[29:0] == 30'd0) begin
         pw = pw - 32'd1;
      end
      piece = (pw > 32'd2) ? 2'd2 : pw[1:0];
      side_in = '{zero: zero, piece: piece, x: x[31:0]};
      row = coef_row(k, piece);
      p_in = row[HORNER_STEPS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      mag_ff <= mag_in;
      prod_ff <= prod_in;
      side_ff <= side_in;
      p_ff <= p_in;
   end

   assign hv[0] = v3_ff;
   assign hp[0] = p_ff;
   assign hs[0] = side_ff;

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_step
      ikw_horner u_step (
         .clock(clock), .reset(reset), .in_valid(hv[i]), .in_p(hp[i]),
         .in_side(hs[i]), .k(k), .j(4'(HORNER_STEPS - 1 - i)),
         .out_valid(hv[i+1]), .out_p(hp[i+1]), .out_side(hs[i+1])
      );
   end

   ikw_mulsh u_scale (
      .clock(clock), .reset(reset), .in_valid(hv[HORNER_STEPS]),
      .in_a(hs[HORNER_STEPS].zero ? 64'sd0 : hp[HORNER_STEPS]),
      .in_b($signed({32'b0, inv})), .shift(SHIFT_F), .in_side('0),
      .out_valid(out_valid), .out_p(f), .out_side()
   );

endmodule

[sv/interpolation_kernel_weight_top.sv]
// ----------------------------------------------------------------------------
// interpolation_kernel_weight_top
// Tensor-product immersed-boundary kernel weight, saturated signed Q24.24.
// ----------------------------------------------------------------------------
// The path from an accepted start to the rsp_valid strobe holds
// 3 front stages, 9 Horner steps of 5 stages, 4 for spacing scale, 4 for
// the cross-dimension product and 1 for saturation.
// Throughput is one transaction per cycle; busy stays low and the receiver
// cannot stall. Synchronous reset clears the valid pipeline and sets
// kernel_select to hat and inv_spacing to 1.0.
module interpolation_kernel_weight_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_offset_0,
   input  logic signed [31:0] req_offset_1,
   output logic               rsp_valid,
   output logic signed [47:0] rsp_weight,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);
   import ikw_pkg::*;

   localparam logic REG_KSEL = 1'b0;
   localparam logic signed [63:0] TOP = (64'sd1 <<< 47) - 64'sd1;
   localparam logic signed [63:0] BOTTOM = -(64'sd1 <<< 47);

   logic [2:0] ksel_ff;
   logic [31:0] inv_ff;
   logic wr;
   logic accept;
   logic v0, v1;
   logic signed [63:0] f0, f1, f1_sel, acc;
   logic acc_valid;
   logic rsp_valid_ff;
   logic signed [47:0] rsp_weight_ff, rsp_weight_in;

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;
   assign wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_KSEL) ? {29'b0, ksel_ff} : inv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ksel_ff <= K_HAT;
         inv_ff <= 32'd65536;
      end else if (wr) begin
         if (paddr[2] == REG_KSEL) begin
            ksel_ff <= pwdata[2:0];
         end else begin
            inv_ff <= pwdata;
         end
      end
   end

   ikw_lane u_lane0 (
      .clock(clock), .reset(reset), .in_valid(accept), .offset(req_offset_0),
      .k(ksel_ff), .inv(inv_ff), .out_valid(v0), .f(f0)
   );

   ikw_lane u_lane1 (
      .clock(clock), .reset(reset), .in_valid(accept), .offset(req_offset_1),
      .k(ksel_ff), .inv(inv_ff), .out_valid(v1), .f(f1)
   );

   // A single dimension multiplies by 1.0 in Q.24, which leaves f0 as is.
   assign f1_sel = (DIMENSIONS >= NUM_OFFSETS) ? f1 : (64'sd1 <<< 24);

   ikw_mulsh u_cross (
      .clock(clock), .reset(reset), .in_valid(v0 & (v1 | (DIMENSIONS < NUM_OFFSETS))),
      .in_a(f0), .in_b(f1_sel), .shift(FRAC_W), .in_side('0),
      .out_valid(acc_valid), .out_p(acc), .out_side()
   );

   always_comb begin
      if (acc > TOP) begin
         rsp_weight_in = TOP[47:0];
      end else if (acc < BOTTOM) begin
         rsp_weight_in = BOTTOM[47:0];
      end else begin
         rsp_weight_in = acc[47:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= acc_valid;
      end
      rsp_weight_ff <= rsp_weight_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;

endmodule

[sim/ikw_checker.sv]
// ----------------------------------------------------------------------------
// ikw_checker
// Watches the request, result and register ports of the kernel weight block.
// It predicts each weight from the offsets and register values seen so far,
// and compares every result strobe with the oldest predicted weight.
// ----------------------------------------------------------------------------
module ikw_checker #(
   parameter logic [2:0] ADDR_KERNEL_SELECT = 3'd0,
   parameter logic [2:0] ADDR_INV_SPACING = 3'd4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic signed [31:0] req_offset_0,
   input  logic signed [31:0] req_offset_1,
   input  logic               rsp_valid,
   input  logic signed [47:0] rsp_weight,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic               pready,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output int                 fail_count,
   output int                 pending
);
   import ikw_pkg::*;

   typedef longint coef_set_type [10];

   localparam logic [127:0] PRODUCT_CAP = 128'd1 << 62;

   logic [2:0]  kernel_ff;
   logic [31:0] inv_spacing_ff;
   logic [47:0] weight_q [$];

   // Exact rational rounded to nearest in Q.36.
   function automatic longint q36(input longint n, input longint d);
      return ((n <<< 36) + d / 2) / d;
   endfunction

   function automatic coef_set_type coefs(input logic [2:0] k, input int pc);
      coef_set_type c;
      c = '{default: 0};
      case (k)
         K_HAT: c = '{q36(1,1), -q36(1,1), 0, 0, 0, 0, 0, 0, 0, 0};
         K_CUBIC, K_L21:
            if (pc == 0) c = '{q36(1,1), 0, -q36(5,2), q36(3,2), 0, 0, 0, 0, 0, 0};
            else c = '{q36(2,1), -q36(4,1), q36(5,2), -q36(1,2), 0, 0, 0, 0, 0, 0};
         K_FOUR:
            if (pc == 0) c = '{q36(1,1), -q36(1,2), -q36(1,1), q36(1,2), 0, 0, 0, 0, 0, 0};
            else c = '{q36(1,1), -q36(11,6), q36(1,1), -q36(1,6), 0, 0, 0, 0, 0, 0};
         K_SIX:
            if (pc == 0)
               c = '{q36(1,1), -q36(1,3), -q36(5,4), q36(5,12), q36(1,4), -q36(1,12),
                     0, 0, 0, 0};
            else if (pc == 1)
               c = '{q36(1,1), -q36(13,12), -q36(5,8), q36(25,24), -q36(3,8), q36(1,24),
                     0, 0, 0, 0};
            else
               c = '{q36(1,1), -q36(137,60), q36(15,8), -q36(17,24), q36(1,8),
                     -q36(1,120), 0, 0, 0, 0};
         K_L22:
            if (pc == 0)
               c = '{q36(1,1), 0, -q36(1,1), -q36(9,2), q36(15,2), -q36(3,1), 0, 0, 0, 0};
            else
               c = '{-q36(4,1), q36(18,1), -q36(29,1), q36(43,2), -q36(15,2), q36(1,1),
                     0, 0, 0, 0};
         K_L42:
            if (pc == 0)
               c = '{q36(1,1), 0, -q36(5,4), -q36(35,12), q36(21,4), -q36(25,12),
                     0, 0, 0, 0};
            else if (pc == 1)
               c = '{-q36(4,1), q36(75,4), -q36(245,8), q36(545,24), -q36(63,8),
                     q36(25,24), 0, 0, 0, 0};
            else
               c = '{q36(18,1), -q36(153,4), q36(255,8), -q36(313,24), q36(21,8),
                     -q36(5,24), 0, 0, 0, 0};
         default:
            if (pc == 0)
               c = '{q36(1,1), 0, -q36(5,4), 0, q36(1,4), -q36(100,3), q36(455,4),
                     -q36(295,2), q36(345,4), -q36(115,6)};
            else if (pc == 1)
               c = '{-q36(199,1), q36(5485,4), -q36(32975,8), q36(28425,4),
                     -q36(61953,8), q36(33175,6), -q36(20685,8), q36(3055,4),
                     -q36(1035,8), q36(115,12)};
            else
               c = '{q36(5913,1), -q36(89235,4), q36(297585,8), -q36(143895,4),
                     q36(177871,8), -q36(54641,6), q36(19775,8), -q36(1715,4),
                     q36(345,8), -q36(23,12)};
      endcase
      return c;
   endfunction

   // Signed product shifted right, truncated toward zero, magnitude capped.
   function automatic longint scaled_product(input longint a, input longint b, input int s);
      logic         neg;
      logic [63:0]  ua, ub;
      logic [127:0] prod;
      neg = (a < 0) != (b < 0);
      ua = (a < 0) ? 64'd0 - 64'(a) : 64'(a);
      ub = (b < 0) ? 64'd0 - 64'(b) : 64'(b);
      prod = ({64'd0, ua} * {64'd0, ub}) >> s;
      if (prod > PRODUCT_CAP) prod = PRODUCT_CAP;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic longint kernel_value(input logic [2:0] k, input logic [63:0] x);
      logic [63:0]  lim;
      int           pc;
      longint       acc;
      coef_set_type c;
      lim = 64'(support_len(k)) << 30;
      if (k <= K_SIX) begin
         // Closed pieces: an exact integer belongs to the piece below it.
         if (x > lim) return 0;
         pc = int'(x >> 30);
         if (pc > 0 && x[29:0] == 30'd0) pc--;
      end else begin
         if (x >= lim) return 0;
         pc = int'(x >> 30);
      end
      if (pc > 2) pc = 2;
      c = coefs(k, pc);
      acc = 0;
      for (int j = 9; j >= 0; j--) acc = scaled_product(acc, longint'(x), 30) + c[j];
      return acc;
   endfunction

   function automatic logic [47:0] predict_weight(input logic [31:0] off0,
                                                  input logic [31:0] off1);
      longint      acc, v, f;
      logic [31:0] raw;
      logic [63:0] mag, x;
      acc = longint'(1) <<< 24;
      for (int i = 0; i < 2; i++) begin
         raw = (i == 0) ? off0 : off1;
         mag = raw[31] ? (64'd1 << 32) - 64'(raw) : 64'(raw);
         x = (mag * 64'(inv_spacing_ff)) >> 2;
         v = kernel_value(kernel_ff, x);
         f = scaled_product(v, longint'(64'(inv_spacing_ff)), 28);
         acc = scaled_product(acc, f, 24);
      end
      if (acc > (longint'(1) <<< 47) - 1) acc = (longint'(1) <<< 47) - 1;
      if (acc < -(longint'(1) <<< 47)) acc = -(longint'(1) <<< 47);
      return acc[47:0];
   endfunction

   always @(posedge clock) begin
      logic [47:0] want;
      if (reset) begin
         kernel_ff <= K_HAT;
         inv_spacing_ff <= 32'd65536;
         weight_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_KERNEL_SELECT) kernel_ff <= pwdata[2:0];
            else if (paddr == ADDR_INV_SPACING) inv_spacing_ff <= pwdata;
         end
         if (start && !busy) weight_q.push_back(predict_weight(req_offset_0, req_offset_1));
         if (rsp_valid) begin
            if (weight_q.size() == 0) begin
               if (fail_count < 10)
                  $display("Unexpected result: weight %h with nothing outstanding",
                           rsp_weight);
               fail_count <= fail_count + 1;
            end else begin
               want = weight_q.pop_front();
               if (want !== rsp_weight) begin
                  if (fail_count < 10)
                     $display("Weight mismatch: expected %h, actual %h", want, rsp_weight);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending <= weight_q.size();
      end
   end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the interpolation kernel weight block: a directed set of
// offsets, then random bursts over every kernel and a range of spacings.
// ----------------------------------------------------------------------------
module tb_top;
   import ikw_pkg::*;

   localparam logic [2:0] ADDR_KERNEL_SELECT = 3'd0;
   localparam logic [2:0] ADDR_INV_SPACING = 3'd4;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_offset_0;
   logic signed [31:0] req_offset_1;
   logic               rsp_valid;
   logic signed [47:0] rsp_weight;
   logic               psel, penable, pwrite, pready;
   logic [2:0]         paddr;
   logic [31:0]        pwdata, prdata;
   int                 fail_count, pending;
   int                 burst_left;
   logic [31:0]        inv_now;

   always #1 clock = ~clock;

   interpolation_kernel_weight_top i_dut (
      .clock, .reset, .start, .busy, .req_offset_0, .req_offset_1,
      .rsp_valid, .rsp_weight, .psel, .penable, .pwrite, .paddr, .pwdata,
      .prdata, .pready
   );

   ikw_checker #(
      .ADDR_KERNEL_SELECT(ADDR_KERNEL_SELECT),
      .ADDR_INV_SPACING(ADDR_INV_SPACING)
   ) i_checker (
      .clock, .reset, .start, .busy, .req_offset_0, .req_offset_1,
      .rsp_valid, .rsp_weight, .psel, .penable, .pwrite, .pready, .paddr,
      .pwdata, .fail_count, .pending
   );

   task automatic send_offsets(input logic [31:0] o0, input logic [31:0] o1);
      start <= 1'b1;
      req_offset_0 <= o0;
      req_offset_1 <= o1;
      do @(posedge clock); while (busy);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   endtask

   // Lowers start and waits until every predicted weight has arrived.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // Offsets mostly inside the kernel support, with exact integers and noise.
   function automatic logic [31:0] random_offset(input logic [31:0] inv);
      logic [63:0] lim;
      logic [31:0] mag;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return $urandom();
      if (pick == 1) mag = 32'($urandom_range(0, 3)) << 16;
      else begin
         lim = (inv == 0) ? 64'd1 << 31 : (64'd15 << 30) / 64'(inv);
         if (lim > (64'd1 << 31)) lim = 64'd1 << 31;
         mag = $urandom_range(0, 32'(lim));
      end
      return ($urandom_range(0, 1) != 0 || mag == 32'h8000_0000) ? 32'd0 - mag : mag;
   endfunction

   initial begin
      logic [31:0] dir0 [16];
      logic [31:0] dir1 [16];
      logic [31:0] spacings [7];
      dir0 = '{32'd0, 32'd65536, -32'sd65536, 32'd32768, 32'h7FFF_FFFF, 32'h8000_0000,
               32'd0, 32'hFFFF_FFFF, 32'd131072, 32'd196608, 32'd16384, 32'd65535,
               32'd65537, 32'h5555_5555, 32'hAAAA_AAAA, 32'd49152};
      dir1 = '{32'd0, 32'd0, 32'd0, -32'sd32768, 32'd0, 32'd0, 32'h8000_0000, 32'd1,
               32'd65536, 32'd0, 32'd49152, -32'sd65535, 32'd65536, 32'hAAAA_AAAA,
               32'h5555_5555, -32'sd16384};
      spacings = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd32768, 32'd131072, 32'd98304, 32'd0};
      reset <= 1'b1;
      start <= 1'b0;
      req_offset_0 <= 32'd0;
      req_offset_1 <= 32'd0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_KERNEL_SELECT;
      pwdata <= 32'd0;
      burst_left = 5;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed set under the reset settings: hat kernel, unit spacing.
      foreach (dir0[i]) send_offsets(dir0[i], dir1[i]);
      drain();

      for (int k = 0; k < 8; k++) begin
         for (int ph = 0; ph < 2; ph++) begin
            if (ph == 0) inv_now = 32'd65536;
            else begin
               inv_now = spacings[(k + ph) % 7];
               if (inv_now == 0 && k != 1) inv_now = $urandom_range(16384, 262144);
            end
            write_register(ADDR_KERNEL_SELECT, 32'(k));
            write_register(ADDR_INV_SPACING, inv_now);
            repeat (68) send_offsets(random_offset(inv_now), random_offset(inv_now));
            drain();
         end
      end

      repeat (80) @(posedge clock);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

[filelist.f]
sv/ikw_pkg.sv
sv/ikw_mulsh.sv
sv/ikw_horner.sv
sv/ikw_lane.sv
sv/interpolation_kernel_weight_top.sv
sim/ikw_checker.sv
sim/tb_top.sv
